### rtl/cfd_pkg.sv
// Shared constants, opcodes and controller/datapath interface types for the complex FIR decimator.
package cfd_pkg;

   localparam int TAPS    = 64;
   localparam int TAP_W   = $clog2(TAPS);
   localparam int SMP_W   = 16;
   localparam int COEF_W  = 18;
   localparam int PROD_W  = SMP_W + COEF_W;
   localparam int ACC_W   = PROD_W + TAP_W;
   localparam int DEC_W   = 7;
   localparam int PHASE_W = 6;
   localparam int DEC_MAX = 64;
   localparam int POWER_W = 31;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 64;

   localparam logic [REQ_USER_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_COEF  = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_CLEAR = 2'd2;

   typedef logic [TAP_W-1:0] tap_type;

   typedef struct packed {
      logic    push;
      logic    coef_wr;
      logic    clear;
      logic    acc_clear;
      logic    issue;
      tap_type tap;
      logic    round;
      logic    square;
      logic    load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

### rtl/cfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cfd_datapath.sv
// Datapath: delay line and coefficient memories, complex MAC, rounding, power and output register.
module cfd_datapath
   import cfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Round half up by 17 bits, then saturate to the Q1.15 range.
   function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W:0]            biased;
      logic signed [ACC_W-17:0]  shifted;
      logic signed [SMP_W-1:0]   res;
      biased  = {acc[ACC_W-1], acc} + (ACC_W + 1)'(65536);
      shifted = signed'(biased[ACC_W:17]);
      if (shifted > signed'((ACC_W - 16)'(32767))) begin
         res = 16'sh7FFF;
      end else if (shifted < -signed'((ACC_W - 16)'(32768))) begin
         res = 16'sh8000;
      end else begin
         res = SMP_W'(shifted);
      end
      return res;
   endfunction

   logic signed [SMP_W-1:0]  smp_i;
   logic signed [SMP_W-1:0]  smp_q;
   logic [5:0]               coef_idx;
   logic signed [COEF_W-1:0] coef_val;

   assign smp_i    = signed'(req_tdata[15:0]);
   assign smp_q    = signed'(req_tdata[31:16]);
   assign coef_idx = req_tdata[37:32];
   assign coef_val = signed'(req_tdata[55:38]);

   tap_type          wp_ff, wp_in;
   logic [TAPS-1:0]  line_vld_ff, line_vld_in;
   logic [TAP_W:0]   line_sum;
   tap_type          line_addr;
   logic             coef_we;

   always_comb begin
      line_sum = {1'b0, wp_ff} + {1'b0, cmd.tap};
      if (line_sum >= (TAP_W + 1)'(TAPS)) begin
         line_addr = TAP_W'(line_sum - (TAP_W + 1)'(TAPS));
      end else begin
         line_addr = TAP_W'(line_sum);
      end
   end

   assign coef_we = cmd.coef_wr && (32'(coef_idx) < TAPS);

   logic [2*SMP_W-1:0] line_rd;
   logic [COEF_W-1:0]  coef_rd;

   cfd_ram #(.WIDTH(2 * SMP_W), .DEPTH(TAPS)) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wp_ff),
      .wr_data ({smp_q, smp_i}),
      .rd_addr (line_addr),
      .rd_data (line_rd)
   );

   cfd_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (TAP_W'(coef_idx)),
      .wr_data (coef_val),
      .rd_addr (cmd.tap),
      .rd_data (coef_rd)
   );

   // Write pointer and per-entry valid bits; an entry not valid reads as zero.
   always_comb begin
      wp_in       = wp_ff;
      line_vld_in = line_vld_ff;
      if (cmd.clear) begin
         wp_in       = '0;
         line_vld_in = '0;
      end else if (cmd.push) begin
         line_vld_in[wp_ff] = 1'b1;
         if (wp_ff == TAP_W'(TAPS - 1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   logic                     vld_rd_ff;
   logic                     s1_ff, s2_ff;
   logic signed [SMP_W-1:0]  d_i, d_q;
   logic signed [PROD_W-1:0] prod_i_ff, prod_q_ff;
   logic signed [ACC_W-1:0]  acc_i_ff, acc_q_ff, acc_i_in, acc_q_in;

   assign d_i = vld_rd_ff ? signed'(line_rd[SMP_W-1:0])       : '0;
   assign d_q = vld_rd_ff ? signed'(line_rd[2*SMP_W-1:SMP_W]) : '0;

   always_comb begin
      acc_i_in = acc_i_ff;
      acc_q_in = acc_q_ff;
      if (cmd.acc_clear) begin
         acc_i_in = '0;
         acc_q_in = '0;
      end else if (s2_ff) begin
         acc_i_in = acc_i_ff + ACC_W'(prod_i_ff);
         acc_q_in = acc_q_ff + ACC_W'(prod_q_ff);
      end
   end

   logic signed [SMP_W-1:0]   out_i_ff, out_q_ff;
   logic signed [2*SMP_W-1:0] sq_i_full, sq_q_full;
   logic [POWER_W-1:0]        sq_i_ff, sq_q_ff;
   logic [POWER_W:0]          pw_sum;
   logic [POWER_W-1:0]        pw_sat;

   assign sq_i_full = out_i_ff * out_i_ff;
   assign sq_q_full = out_q_ff * out_q_ff;
   assign pw_sum    = {1'b0, sq_i_ff} + {1'b0, sq_q_ff};
   assign pw_sat    = pw_sum[POWER_W] ? '1 : pw_sum[POWER_W-1:0];

   logic                 rsp_vld_ff;
   logic [SMP_W-1:0]     rsp_i_ff, rsp_q_ff;
   logic [POWER_W-1:0]   rsp_pw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         line_vld_ff <= '0;
         vld_rd_ff   <= 1'b0;
         s1_ff       <= 1'b0;
         s2_ff       <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         line_vld_ff <= line_vld_in;
         vld_rd_ff   <= line_vld_ff[line_addr];
         s1_ff       <= cmd.issue;
         s2_ff       <= s1_ff;
         if (cmd.load_out) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      prod_i_ff <= signed'(coef_rd) * d_i;
      prod_q_ff <= signed'(coef_rd) * d_q;
      acc_i_ff  <= acc_i_in;
      acc_q_ff  <= acc_q_in;
      if (cmd.round) begin
         out_i_ff <= round_sat(acc_i_ff);
         out_q_ff <= round_sat(acc_q_ff);
      end
      if (cmd.square) begin
         sq_i_ff <= POWER_W'(unsigned'(sq_i_full));
         sq_q_ff <= POWER_W'(unsigned'(sq_q_full));
      end
      if (cmd.load_out) begin
         rsp_i_ff  <= out_i_ff;
         rsp_q_ff  <= out_q_ff;
         rsp_pw_ff <= pw_sat;
      end
   end

   assign sts.out_free = !rsp_vld_ff || rsp_tready;
   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = {1'b0, rsp_pw_ff, rsp_q_ff, rsp_i_ff};

endmodule

### rtl/cfd_controller.sv
// Controller: request decode, decimation phase, tap sequencing and result hand-off.
module cfd_controller
   import cfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DEC_W-1:0]      csr_data,
   output dp_cmd_type            cmd,
   input  dp_sts_type            sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_SQUARE,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   tap_type            tap_ff;
   logic               drain_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [DEC_W-1:0]   dec_ff;

   logic             accept;
   logic [DEC_W-1:0] dec_eff;
   logic [DEC_W-1:0] phase_nx;
   logic             emit;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (dec_ff == '0) begin
         dec_eff = DEC_W'(1);
      end else if (dec_ff > DEC_W'(DEC_MAX)) begin
         dec_eff = DEC_W'(DEC_MAX);
      end else begin
         dec_eff = dec_ff;
      end
   end

   assign phase_nx = DEC_W'(phase_ff) + 1'b1;
   assign emit     = (phase_nx >= dec_eff);

   always_comb begin
      cmd           = '0;
      cmd.tap       = tap_ff;
      cmd.issue     = (state_ff == ST_MAC);
      cmd.round     = (state_ff == ST_ROUND);
      cmd.square    = (state_ff == ST_SQUARE);
      cmd.load_out  = (state_ff == ST_FINISH) && sts.out_free;
      if (accept) begin
         unique case (req_tuser)
            OP_PUSH: begin
               cmd.push      = 1'b1;
               cmd.acc_clear = emit;
            end
            OP_COEF:  cmd.coef_wr = 1'b1;
            OP_CLEAR: cmd.clear   = 1'b1;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         drain_ff <= 1'b0;
         phase_ff <= '0;
         dec_ff   <= DEC_W'(1);
      end else begin
         if (csr_valid) begin
            dec_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_tuser)
                     OP_PUSH: begin
                        if (emit) begin
                           phase_ff <= '0;
                           tap_ff   <= '0;
                           state_ff <= ST_MAC;
                        end else begin
                           phase_ff <= PHASE_W'(phase_nx);
                        end
                     end
                     OP_CLEAR: phase_ff <= '0;
                     default:  ;
                  endcase
               end
            end
            ST_MAC: begin
               tap_ff <= tap_ff + 1'b1;
               if (tap_ff == TAP_W'(TAPS - 1)) begin
                  drain_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND:  state_ff <= ST_SQUARE;
            ST_SQUARE: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (sts.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### rtl/complex_fir_decimator.sv
// Top level of the complex I/Q FIR decimator: controller, datapath and ports.
// A request that completes a decimation period has its response valid after the tap states
// run through the single complex MAC pair, then the pipeline drain states, rounding, squaring
// and the output load; all other requests complete on acceptance.
// Throughput: one request per cycle except after an emitting push, which holds off new
// requests until its result is loaded, which waits while an earlier response is not yet taken.
// Reset is synchronous, active high, clears the delay line, pointer, phase and output, and
// sets the decimation factor to 1; coefficients stay undefined until written.
module complex_fir_decimator
   import cfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata fields from bit 0: sample_i[15:0], sample_q[31:16], coef_index[37:32],
   // coef_value[55:38].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser fields from bit 0: opcode[1:0].
   input  logic [REQ_USER_W-1:0] req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata fields from bit 0: out_i[15:0], out_q[31:16], power[62:32], zero pad[63].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Decimation factor write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DEC_W-1:0]      csr_data
);

   // The controller decodes each request and sequences the taps; the datapath holds the
   // memories, the MAC pipeline and the response register that lets the next request in
   // while a finished result still waits.
   dp_cmd_type cmd;
   dp_sts_type sts;

   cfd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

   cfd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/cfd_checker.sv
// Port-level assertions for the complex FIR decimator and the bind that attaches them.
module cfd_checker
   import cfd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A response that is held back keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Requests other than a push never start a computation.
   a_nonpush_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != OP_PUSH) |=> req_tready)
      else $error("non-push request blocked the request channel");

   // A new response appears only at the end of a computation, while requests are held off.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without a computation");

endmodule

bind complex_fir_decimator cfd_checker u_cfd_checker (.*);

### sim/complex_fir_decimator_tb.sv
// Self-checking testbench for the complex I/Q FIR decimator with a built-in filter predictor.
module complex_fir_decimator_tb;
   import cfd_pkg::*;

   // The request opcode that the block must ignore has no name in the package.
   localparam logic [REQ_USER_W-1:0] OP_IGNORED = 2'd3;

   // Cycles to let pass before a decimation write, covering a full emitting push.
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 100;

   typedef struct packed {
      logic signed [SMP_W-1:0] out_i;
      logic signed [SMP_W-1:0] out_q;
      logic [POWER_W-1:0]      power;
   } fir_result_type;

   typedef enum logic {ROW_REQUEST, ROW_SETTING} row_kind_type;

   // One line of the directed table: either a request or a decimation write.
   typedef struct packed {
      row_kind_type             kind;
      logic [REQ_USER_W-1:0]    op;
      logic signed [SMP_W-1:0]  smp_i;
      logic signed [SMP_W-1:0]  smp_q;
      logic [TAP_W-1:0]         idx;
      logic signed [COEF_W-1:0] coef;
      logic [DEC_W-1:0]         dec;
      logic                     typed;
      fir_result_type           want;
   } stim_row_type;

   localparam int N_DIRECTED = 24;

   // Rows with a typed result can be worked out by hand. All taps start at zero, then taps 62
   // and 63 are set to minus one so the newest two samples are negated and summed, which drives
   // both outputs and the power into saturation. After the clear, tap 63 is one half, which
   // shows the round-half-up behavior on odd samples.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REQUEST, OP_PUSH, 16'sd1000, -16'sd2000, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{16'sd0, 16'sd0, 31'd0}},
      '{ROW_REQUEST, OP_COEF, 16'sd0, 16'sd0, 6'd63, 18'h20000, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, 16'sd32767, 16'sd32767, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{-16'sd32767, -16'sd32767, 31'd2147352578}},
      '{ROW_REQUEST, OP_COEF, 16'sd0, 16'sd0, 6'd62, 18'h20000, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, 16'sd32767, 16'sd32767, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{16'h8000, 16'h8000, 31'd2147483647}},
      '{ROW_REQUEST, OP_PUSH, 16'h8000, 16'h8000, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{16'sd1, 16'sd1, 31'd2}},
      '{ROW_REQUEST, OP_PUSH, 16'h8000, 16'h8000, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{16'sd32767, 16'sd32767, 31'd2147352578}},
      '{ROW_REQUEST, OP_CLEAR, 16'h7FFF, 16'h8000, 6'd63, 18'h3FFFF, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_COEF, 16'sd0, 16'sd0, 6'd62, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_COEF, 16'sd0, 16'sd0, 6'd63, 18'sd65536, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, 16'sd1, -16'sd1, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{16'sd1, 16'sd0, 31'd1}},
      '{ROW_REQUEST, OP_PUSH, 16'sd3, -16'sd3, 6'd0, 18'sd0, 7'd0, 1'b1,
        '{16'sd2, -16'sd1, 31'd5}},
      '{ROW_REQUEST, OP_COEF, 16'sd0, 16'sd0, 6'd0, 18'sd131071, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_IGNORED, 16'h5A5A, 16'hA5A5, 6'd17, 18'h2AAAA, 7'd0, 1'b0, '0},
      '{ROW_SETTING, OP_PUSH, 16'sd0, 16'sd0, 6'd0, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, 16'sd12345, -16'sd23456, 6'd0, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_SETTING, OP_PUSH, 16'sd0, 16'sd0, 6'd0, 18'sd0, 7'd2, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, -16'sd1, 16'sd1, 6'd0, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, 16'sd100, 16'sd200, 6'd0, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, 16'sd7, 16'sd9, 6'd0, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST, OP_CLEAR, 16'sd0, 16'sd0, 6'd0, 18'sd0, 7'd0, 1'b0, '0},
      '{ROW_SETTING, OP_PUSH, 16'sd0, 16'sd0, 6'd0, 18'sd0, 7'd127, 1'b0, '0},
      '{ROW_SETTING, OP_PUSH, 16'sd0, 16'sd0, 6'd0, 18'sd0, 7'd1, 1'b0, '0},
      '{ROW_REQUEST, OP_PUSH, -16'sd30000, 16'sd29999, 6'd0, 18'sd0, 7'd0, 1'b0, '0}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = OP_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [DEC_W-1:0]      csr_data   = '0;

   // Predictor state: its own copy of the delay lines, taps, pointer, phase and register.
   logic signed [SMP_W-1:0]  hist_i [TAPS];
   logic signed [SMP_W-1:0]  hist_q [TAPS];
   logic signed [COEF_W-1:0] tap_coef [TAPS];
   int unsigned              hist_ptr;
   int unsigned              push_phase;
   logic [DEC_W-1:0]         dec_factor;

   fir_result_type filtered_outputs [$];

   int mismatches        = 0;
   int requests_accepted = 0;
   int results_checked   = 0;
   int settings_written  = 0;
   int cycle_count       = 0;
   int burst_left        = 0;
   int stall_mode        = 0;

   complex_fir_decimator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_history();
      for (int k = 0; k < TAPS; k++) begin
         hist_i[k] = '0;
         hist_q[k] = '0;
      end
      hist_ptr   = 0;
      push_phase = 0;
   endfunction

   // The Q8.32 sum is brought back to Q1.15 rounding half toward plus infinity, then clipped.
   function automatic logic signed [SMP_W-1:0] round_to_q15(input longint acc);
      longint t;
      t = (acc + 65536) >>> 17;
      if (t > 32767)
         t = 32767;
      else if (t < -32768)
         t = -32768;
      return t[SMP_W-1:0];
   endfunction

   // Applies one accepted request to the predictor; returns 1 when it yields a result.
   function automatic bit apply_request(input logic [REQ_USER_W-1:0] op,
                                        input logic [REQ_DATA_W-1:0] data,
                                        output fir_result_type res);
      longint      acc_i;
      longint      acc_q;
      longint      pwr;
      int unsigned eff_dec;
      int unsigned pos;
      res = '0;
      case (op)
         OP_COEF: begin
            tap_coef[data[37:32]] = data[55:38];
            return 1'b0;
         end
         OP_CLEAR: begin
            clear_history();
            return 1'b0;
         end
         OP_PUSH: ;
         default: return 1'b0;
      endcase

      hist_i[hist_ptr] = data[15:0];
      hist_q[hist_ptr] = data[31:16];
      hist_ptr = (hist_ptr + 1) % TAPS;

      // A factor of zero behaves as one and anything above the maximum as the maximum.
      eff_dec = (dec_factor == 0) ? 1 : (dec_factor > DEC_MAX) ? DEC_MAX : dec_factor;
      push_phase++;
      if (push_phase < eff_dec)
         return 1'b0;
      push_phase = 0;

      // The pointer now sits on the oldest sample, which tap 0 weights.
      acc_i = 0;
      acc_q = 0;
      for (int k = 0; k < TAPS; k++) begin
         pos = (hist_ptr + k) % TAPS;
         acc_i += longint'(tap_coef[k]) * longint'(hist_i[pos]);
         acc_q += longint'(tap_coef[k]) * longint'(hist_q[pos]);
      end
      res.out_i = round_to_q15(acc_i);
      res.out_q = round_to_q15(acc_q);
      pwr = longint'(res.out_i) * longint'(res.out_i) + longint'(res.out_q) * longint'(res.out_q);
      if (pwr > 2147483647)
         pwr = 2147483647;
      res.power = pwr[POWER_W-1:0];
      return 1'b1;
   endfunction

   // Sends one request in bursts with random gaps between them. The valid is never lowered in
   // the step where the next request raises it, so back-to-back requests keep it high.
   task automatic send_request(input logic [REQ_USER_W-1:0] op,
                               input logic [REQ_DATA_W-1:0] data,
                               input bit typed, input fir_result_type typed_want);
      fir_result_type predicted;
      int             gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      requests_accepted++;
      if (apply_request(op, data, predicted))
         filtered_outputs = {filtered_outputs, (typed ? typed_want : predicted)};
   endtask

   // Brings the block to rest: no request pending, every result delivered, pipeline drained.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (filtered_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_decimation(input logic [DEC_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dec_factor = value;
      settings_written++;
   endtask

   // Samples lean toward the two extremes so saturation is hit often.
   function automatic logic [SMP_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return SMP_W'($urandom());
      endcase
   endfunction

   // Mostly small taps keep the outputs in range; extremes and full-width values still appear.
   function automatic logic [COEF_W-1:0] pick_coef();
      logic signed [COEF_W-1:0] small_coef;
      small_coef = $signed(COEF_W'($urandom_range(0, 4095))) - 18'sd2048;
      case ($urandom_range(0, 7))
         0:       return 18'h20000;
         1:       return 18'h1FFFF;
         2, 3:    return COEF_W'($urandom());
         default: return small_coef;
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_bits();
      return REQ_DATA_W'({$urandom(), $urandom()});
   endfunction

   // The receiver switches between always ready, coin-flip ready and mostly stalled modes,
   // so stalls land on every part of the result traffic.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0)
         stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Each delivered result is compared with the oldest prediction.
   always @(posedge clock) begin : response_check
      fir_result_type got;
      fir_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_i = rsp_tdata[15:0];
         got.out_q = rsp_tdata[31:16];
         got.power = rsp_tdata[62:32];
         if (filtered_outputs.size() == 0) begin
            $error("unexpected result: out_i %0d out_q %0d power %0d",
                   got.out_i, got.out_q, got.power);
            mismatches++;
         end else begin
            want = filtered_outputs.pop_front();
            results_checked++;
            if (got.out_i !== want.out_i) begin
               $error("out_i expected %0d actual %0d", want.out_i, got.out_i);
               mismatches++;
            end
            if (got.out_q !== want.out_q) begin
               $error("out_q expected %0d actual %0d", want.out_q, got.out_q);
               mismatches++;
            end
            if (got.power !== want.power) begin
               $error("power expected %0d actual %0d", want.power, got.power);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [REQ_DATA_W-1:0] data;
      logic [REQ_USER_W-1:0] op;
      logic [DEC_W-1:0]      phase_setting [8];
      int                    pick;

      for (int k = 0; k < TAPS; k++)
         tap_coef[k] = '0;
      dec_factor = DEC_W'(1);
      clear_history();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Taps read as undefined until written, so every tap is zeroed before the first push.
      for (int k = 0; k < TAPS; k++) begin
         data = random_bits();
         data[55:32] = {18'sd0, TAP_W'(k)};
         send_request(OP_COEF, data, 1'b0, '0);
      end

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_SETTING)
            write_decimation(directed_rows[n].dec);
         else
            send_request(directed_rows[n].op,
                         {directed_rows[n].coef, directed_rows[n].idx,
                          directed_rows[n].smp_q, directed_rows[n].smp_i},
                         directed_rows[n].typed, directed_rows[n].want);
      end

      // Fresh taps for the random part, mostly small so the outputs are not all clipped.
      for (int k = 0; k < TAPS; k++) begin
         data = random_bits();
         data[55:32] = {pick_coef(), TAP_W'(k)};
         send_request(OP_COEF, data, 1'b0, '0);
      end

      // Random phases run under several factors, the out-of-range ones included.
      phase_setting = '{7'd1, 7'd4, 7'd0, 7'd64, 7'd127, 7'd3, 7'd1, 7'd1};
      phase_setting[6] = DEC_W'($urandom_range(2, DEC_MAX - 1));
      foreach (phase_setting[p]) begin
         write_decimation(phase_setting[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            op = (pick < 80) ? OP_PUSH : (pick < 90) ? OP_COEF :
                 (pick < 95) ? OP_CLEAR : OP_IGNORED;
            data = random_bits();
            data[15:0]  = pick_sample();
            data[31:16] = pick_sample();
            if (op == OP_COEF)
               data[55:38] = pick_coef();
            send_request(op, data, 1'b0, '0);
         end
      end

      settle_block();
      $display("Run covered %0d requests, %0d filtered results and %0d decimation settings.",
               requests_accepted, results_checked, settings_written);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
